[src/wbps_pkg.sv]
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int SIG_BYTES   = 16;
   localparam int SIG_IDX_W   = 4;
   localparam int ADDR_W      = 48;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int LEN_W       = 5;
   localparam int MASK_W      = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LO = 3'd0,
      CSR_PAT_HI = 3'd1,
      CSR_WILD   = 3'd2,
      CSR_LEN    = 3'd3,
      CSR_BASE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic       active;
      logic       wild;
      logic [7:0] expect_byte;
   } cell_cfg_type;

   typedef struct packed {
      logic              match_found;
      logic [ADDR_W-1:0] match_address;
      logic              scan_done;
   } rsp_item_type;

endpackage

[src/wbps_cell.sv]
// One window position: holds a byte, passes it on, compares the incoming byte.
module wbps_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic                  clear,
   input  logic [7:0]            byte_in,
   input  wbps_pkg::cell_cfg_type cfg,
   output logic [7:0]            byte_out,
   output logic                  hit
);
   import wbps_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;

   // The incoming byte is what this position holds once the item is taken.
   assign hit = !cfg.active || cfg.wild || (byte_in == cfg.expect_byte);

   always_comb begin
      byte_in_next = byte_ff;
      if (clear) begin
         byte_in_next = 8'd0;
      end else if (shift) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

[src/wbps_rsp_buf.sv]
// Two-entry result buffer: output register plus skid entry.
module wbps_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wbps_pkg::rsp_item_type push_item,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wbps_pkg::rsp_item_type rsp_item
);
   import wbps_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         out_pop;

   assign out_pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         // input is stalled; drain the skid entry into the output
         if (out_pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || out_pop) begin
            out_valid_in = 1'b1;
            out_item_in  = push_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = push_item;
         end
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

[src/wildcard_byte_pattern_scanner.sv]
// Top level of the wildcard byte pattern scanner.
//
// Bytes of a memory image enter on the req_ channel (req_data_byte, with
// req_last_byte on the final byte). Each byte shifts into a row of
// MAX_PATTERN window cells; every cell compares the byte it takes against
// its signature byte, so a whole window compare happens in the cycle the
// byte is accepted. One item is taken per cycle, back to back, while req_stall is low.
// A result is registered into the output buffer when its item is accepted
// and the window matches or the byte is the final one; other bytes give
// no result. match_address is base_address plus the match start offset.
// Results go through a two-entry buffer; req_stall rises only when both
// entries hold results and the receiver stalls, and falls as soon as the
// output drains one.
// Registers are written on the csr_ port (csr_ready stays high); the user must
// write them only while no item is in flight; the block does not enforce it.
// Reset (synchronous) clears the window, the byte counter and the buffer and
// returns all registers to their reset values; req_stall is low out of reset.
module wildcard_byte_pattern_scanner #(
   parameter int MAX_PATTERN  = 16,
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_match_found,
   output logic [wbps_pkg::ADDR_W-1:0]         rsp_match_address,
   output logic                                rsp_scan_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_data
);
   import wbps_pkg::*;

   localparam int LEN_CAP = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

   // configuration registers
   logic [CSR_DATA_W-1:0] pat_lo_ff;
   logic [CSR_DATA_W-1:0] pat_hi_ff;
   logic [MASK_W-1:0]     wild_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [ADDR_W-1:0]     base_ff;

   logic [OFFSET_WIDTH-1:0] count_ff, count_in;
   logic [OFFSET_WIDTH-1:0] count_step;
   logic [OFFSET_WIDTH-1:0] offset;
   logic [LEN_W-1:0]        len_eff;
   logic [SIG_BYTES-1:0][7:0] sig_bytes;

   logic                accept;
   logic                clear;
   logic                window_hit;
   logic                hit;
   logic                emit;
   logic                buf_full;
   rsp_item_type        new_item;
   rsp_item_type        out_item;

   cell_cfg_type        cell_cfg [MAX_PATTERN];
   logic [7:0]          chain    [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         wild_ff   <= '0;
         len_ff    <= LEN_W'(1);
         base_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAT_LO: pat_lo_ff <= csr_data;
            CSR_PAT_HI: pat_hi_ff <= csr_data;
            CSR_WILD:   wild_ff   <= csr_data[MASK_W-1:0];
            CSR_LEN:    len_ff    <= csr_data[LEN_W-1:0];
            CSR_BASE:   base_ff   <= csr_data[ADDR_W-1:0];
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   always_comb begin
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(LEN_CAP)) begin
         len_eff = LEN_W'(LEN_CAP);
      end
   end

   assign sig_bytes = {pat_hi_ff, pat_lo_ff};

   assign accept = req_valid && !req_stall;
   assign clear  = accept && req_last_byte;
   assign chain[0] = req_data_byte;

   // Cell i compares the byte of age i (age 0 is the incoming one) with signature byte len-1-i.
   for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      if (gi < LEN_CAP) begin : g_cfg
         logic [LEN_W-1:0] pos;
         assign pos = len_eff - LEN_W'(gi + 1);
         assign cell_cfg[gi].active      = LEN_W'(gi) < len_eff;
         assign cell_cfg[gi].wild        = wild_ff[pos[SIG_IDX_W-1:0]];
         assign cell_cfg[gi].expect_byte = sig_bytes[pos[SIG_IDX_W-1:0]];
      end else begin : g_idle
         assign cell_cfg[gi] = '0;
      end

      if (gi < MAX_PATTERN - 1) begin : g_mid
         wbps_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .clear    (clear),
            .byte_in  (chain[gi]),
            .cfg      (cell_cfg[gi]),
            .byte_out (chain[gi+1]),
            .hit      (cell_hit[gi])
         );
      end else begin : g_end
         wbps_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .clear    (clear),
            .byte_in  (chain[gi]),
            .cfg      (cell_cfg[gi]),
            .byte_out (),
            .hit      (cell_hit[gi])
         );
      end
   end

   // saturating byte count, including the byte being accepted
   assign count_step = (&count_ff) ? count_ff : count_ff + OFFSET_WIDTH'(1);
   assign offset     = count_step - OFFSET_WIDTH'(len_eff);
   assign window_hit = &cell_hit;
   assign hit        = window_hit && (count_step >= OFFSET_WIDTH'(len_eff));
   assign emit       = accept && (hit || req_last_byte);

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      new_item.match_found   = hit;
      new_item.match_address = hit ? base_ff + ADDR_W'(offset) : '0;
      new_item.scan_done     = req_last_byte;
   end

   wbps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_item (new_item),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (out_item)
   );

   assign req_stall         = buf_full;
   assign rsp_match_found   = out_item.match_found;
   assign rsp_match_address = out_item.match_address;
   assign rsp_scan_done     = out_item.scan_done;

endmodule

[src/wbps_checker.sv]
// Port-level checks of the wildcard byte pattern scanner, bound to the top level.
module wbps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_match_found,
   input logic [wbps_pkg::ADDR_W-1:0] rsp_match_address,
   input logic                        rsp_scan_done
);
   import wbps_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_found)
         && $stable(rsp_match_address) && $stable(rsp_scan_done))
      else $error("stalled result changed");

   // every item carries a match or the end of the image
   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_found || rsp_scan_done)
      else $error("result with neither match nor done");

   a_no_match_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_address == '0)
      else $error("address set without a match");

   // input stalls only while a result waits at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_match_found   (rsp_match_found),
   .rsp_match_address (rsp_match_address),
   .rsp_scan_done     (rsp_scan_done)
);
